>>> hdl/bhfs_pkg.sv
package bhfs_pkg;

    localparam int BYTE_W   = 8;
    localparam int DCNT_W   = 9;
    localparam int TOTAL_W  = 40;
    localparam int OUT_WT_W = 32;

    typedef enum logic [1:0] {
        OP_COUNT   = 2'd0,
        OP_RESTART = 2'd1,
        OP_READ    = 2'd2,
        OP_CLEAR   = 2'd3
    } bhfs_op_t;

    typedef struct packed {
        bhfs_op_t            op;
        logic [BYTE_W-1:0]   byte_value;
    } bhfs_in_t;

    typedef struct packed {
        logic                entry_valid;
        logic [BYTE_W-1:0]   symbol;
        logic [OUT_WT_W-1:0] weight;
        logic [DCNT_W-1:0]   distinct_count;
        logic [TOTAL_W-1:0]  total_count;
    } bhfs_out_t;

    // Request to the weight memory for one cycle.
    typedef struct packed {
        logic count;   // read-modify-write of a counted byte
        logic fresh;   // first sighting: write 1, ignore read data
        logic lookup;  // plain read for the readout
    } bhfs_wt_cmd_t;

endpackage

>>> hdl/bhfs_order_mem.sv
module bhfs_order_mem
    import bhfs_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [SYM_W-1:0] wr_addr,
    input  logic [SYM_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [SYM_W-1:0] rd_addr,
    output logic [SYM_W-1:0] rd_data
);

    logic [SYM_W-1:0] mem [SYMBOL_COUNT];
    logic [SYM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/bhfs_weight_mem.sv
module bhfs_weight_mem
    import bhfs_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int WEIGHT_WIDTH = 32,
    localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  bhfs_wt_cmd_t            cmd,
    input  logic [SYM_W-1:0]        addr,
    output logic [WEIGHT_WIDTH-1:0] rdata
);

    logic [WEIGHT_WIDTH-1:0] mem [SYMBOL_COUNT];
    logic [WEIGHT_WIDTH-1:0] rd_q_reg;
    logic                    wb_valid_reg;
    logic                    wb_fresh_reg;
    logic [SYM_W-1:0]        wb_addr_reg;
    logic                    fwd_valid_reg;
    logic [SYM_W-1:0]        fwd_addr_reg;
    logic [WEIGHT_WIDTH-1:0] fwd_data_reg;
    logic [WEIGHT_WIDTH-1:0] cur;
    logic [WEIGHT_WIDTH-1:0] wr_data;

    // Forward the write that landed on the same edge as this read.
    always_comb
    begin
        cur = (fwd_valid_reg && (fwd_addr_reg == wb_addr_reg)) ? fwd_data_reg : rd_q_reg;
        if (wb_fresh_reg)
        begin
            wr_data = WEIGHT_WIDTH'(1);
        end
        else if (cur == '1)
        begin
            wr_data = cur;
        end
        else
        begin
            wr_data = cur + WEIGHT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg  <= cmd.count;
            fwd_valid_reg <= wb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_valid_reg)
        begin
            mem[wb_addr_reg] <= wr_data;
        end
        if (cmd.count || cmd.lookup)
        begin
            rd_q_reg    <= mem[addr];
            wb_addr_reg <= addr;
            wb_fresh_reg <= cmd.fresh;
        end
        fwd_addr_reg <= wb_addr_reg;
        fwd_data_reg <= wr_data;
    end

    assign rdata = cur;

endmodule

>>> hdl/byte_histogram_first_seen_top.sv
// Count word: taken every cycle while idle, busy stays low; weight update completes next cycle.
// Read word: busy over order and weight reads, strobe in the cycle after; next word taken with it.
// The read latency comes from two dependent memory reads: order list, then weight memory.
// Restart and clear words leave busy low and give no result.
// Reset clears seen flags, distinct and byte totals and the read position at once.
// Results are shown for one cycle only; the receiver cannot stall.
module byte_histogram_first_seen_top
    import bhfs_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256,
    parameter int WEIGHT_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  bhfs_in_t  command,
    output logic      result_valid,
    output bhfs_out_t result
);

    localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_ORDER,
        ST_RD_WEIGHT
    } state_t;

    state_t                  state_reg, state_next;
    logic [SYMBOL_COUNT-1:0] seen_reg, seen_next;
    logic [DCNT_W-1:0]       distinct_reg, distinct_next;
    logic [TOTAL_W-1:0]      total_reg, total_next;
    logic [DCNT_W-1:0]       rpos_reg, rpos_next;
    logic                    hit_reg, hit_next;
    logic                    strobe_reg, strobe_next;
    bhfs_out_t               result_reg, result_next;

    logic                    accept;
    logic                    in_range;
    logic [SYM_W-1:0]        sym_idx;
    logic                    seen_now;
    logic                    order_wr;
    logic                    order_rd;
    logic [SYM_W-1:0]        order_q;
    bhfs_wt_cmd_t            wt_cmd;
    logic [SYM_W-1:0]        wt_addr;
    logic [WEIGHT_WIDTH-1:0] wt_rdata;
    logic [63:0]             wt_wide;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign in_range = ({1'b0, command.byte_value} < DCNT_W'(SYMBOL_COUNT));
    assign sym_idx  = command.byte_value[SYM_W-1:0];
    assign seen_now = seen_reg[sym_idx];
    assign order_wr = accept && (command.op == OP_COUNT) && in_range && !seen_now;
    assign order_rd = accept && (command.op == OP_READ) && (rpos_reg < distinct_reg);

    always_comb
    begin
        wt_cmd.count  = accept && (command.op == OP_COUNT) && in_range;
        wt_cmd.fresh  = !seen_now;
        wt_cmd.lookup = (state_reg == ST_RD_ORDER) && hit_reg;
        wt_addr       = (state_reg == ST_RD_ORDER) ? order_q : sym_idx;
    end

    bhfs_order_mem #(
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) u_order (
        .clk     (clk),
        .wr_en   (order_wr),
        .wr_addr (distinct_reg[SYM_W-1:0]),
        .wr_data (sym_idx),
        .rd_en   (order_rd),
        .rd_addr (rpos_reg[SYM_W-1:0]),
        .rd_data (order_q)
    );

    bhfs_weight_mem #(
        .SYMBOL_COUNT(SYMBOL_COUNT),
        .WEIGHT_WIDTH(WEIGHT_WIDTH)
    ) u_weight (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (wt_cmd),
        .addr  (wt_addr),
        .rdata (wt_rdata)
    );

    assign wt_wide = 64'(wt_rdata);

    always_comb
    begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        distinct_next = distinct_reg;
        total_next    = total_reg;
        rpos_next     = rpos_reg;
        hit_next      = hit_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command.op)
                        OP_COUNT:
                        begin
                            if (in_range)
                            begin
                                if (!seen_now)
                                begin
                                    seen_next[sym_idx] = 1'b1;
                                    distinct_next      = distinct_reg + DCNT_W'(1);
                                end
                                if (total_reg != '1)
                                begin
                                    total_next = total_reg + TOTAL_W'(1);
                                end
                            end
                        end
                        OP_RESTART:
                        begin
                            rpos_next = '0;
                        end
                        OP_READ:
                        begin
                            hit_next   = (rpos_reg < distinct_reg);
                            if (rpos_reg < distinct_reg)
                            begin
                                rpos_next = rpos_reg + DCNT_W'(1);
                            end
                            state_next = ST_RD_ORDER;
                        end
                        OP_CLEAR:
                        begin
                            seen_next     = '0;
                            distinct_next = '0;
                            total_next    = '0;
                            rpos_next     = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_ORDER:
            begin
                state_next = ST_RD_WEIGHT;
            end
            ST_RD_WEIGHT:
            begin
                strobe_next                = 1'b1;
                result_next.entry_valid    = hit_reg;
                result_next.symbol         = hit_reg ? BYTE_W'(order_q) : '0;
                if (!hit_reg)
                begin
                    result_next.weight = '0;
                end
                else if (wt_wide > 64'h0000_0000_FFFF_FFFF)
                begin
                    result_next.weight = '1;
                end
                else
                begin
                    result_next.weight = wt_wide[OUT_WT_W-1:0];
                end
                result_next.distinct_count = distinct_reg;
                result_next.total_count    = total_reg;
                state_next                 = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            seen_reg     <= '0;
            distinct_reg <= '0;
            total_reg    <= '0;
            rpos_reg     <= '0;
            hit_reg      <= 1'b0;
            strobe_reg   <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            distinct_reg <= distinct_next;
            total_reg    <= total_next;
            rpos_reg     <= rpos_next;
            hit_reg      <= hit_next;
            strobe_reg   <= strobe_next;
            result_reg   <= result_next;
        end
    end

    assign result_valid = strobe_reg;
    assign result       = result_reg;

    a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command.op == OP_READ)) |=> busy)
        else $error("read word did not raise busy");

    a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!busy && $past(state_reg == ST_RD_WEIGHT)))
        else $error("result strobe outside readout");

    a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (distinct_reg <= DCNT_W'(SYMBOL_COUNT)) && (rpos_reg <= distinct_reg))
        else $error("distinct count or read position out of range");

    a_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.entry_valid) |-> ((result.symbol == '0) && (result.weight == '0)))
        else $error("exhausted readout carries a symbol");

endmodule

>>> tb/byte_histogram_first_seen_top_test.sv
module byte_histogram_first_seen_top_test;

    import bhfs_pkg::*;

    localparam int SYMBOLS      = 256;
    localparam int WT_W         = 32;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    bhfs_in_t  command = '0;
    logic      busy;
    logic      result_valid;
    bhfs_out_t result;

    byte_histogram_first_seen_top #(
        .SYMBOL_COUNT (SYMBOLS),
        .WEIGHT_WIDTH (WT_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .result_valid (result_valid),
        .result       (result)
    );

    always #6 clk = ~clk;

    // Histogram mirror, updated at the edge that takes each word.
    logic [SYMBOLS-1:0] seen_mask = '0;
    logic [WT_W-1:0]    sym_weight [SYMBOLS];
    logic [BYTE_W-1:0]  arrival_order [SYMBOLS];
    logic [DCNT_W-1:0]  distinct_seen = '0;
    logic [TOTAL_W-1:0] bytes_counted = '0;
    logic [DCNT_W-1:0]  readout_pos = '0;

    bhfs_in_t  pending_words [$];
    bhfs_out_t expected_reads [$];
    int        words_queued = 0;
    int        words_sent   = 0;
    int        words_taken  = 0;
    int        mismatches   = 0;
    int        cycles       = 0;
    logic      word_taken   = 1'b0;

    task automatic push_word(input bhfs_op_t op, input logic [BYTE_W-1:0] value);
        bhfs_in_t w;
        w.op         = op;
        w.byte_value = value;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic histogram_step(input bhfs_in_t w);
        bhfs_out_t        r;
        logic [BYTE_W-1:0] b;
        b = w.byte_value;
        case (w.op)
            OP_COUNT:
            begin
                if (int'(b) < SYMBOLS)
                begin
                    if (seen_mask[b])
                    begin
                        if (sym_weight[b] != '1)
                            sym_weight[b] = sym_weight[b] + 1'b1;
                    end
                    else
                    begin
                        seen_mask[b] = 1'b1;
                        if (int'(distinct_seen) < SYMBOLS)
                        begin
                            arrival_order[distinct_seen[BYTE_W-1:0]] = b;
                            distinct_seen = distinct_seen + 1'b1;
                        end
                        sym_weight[b] = 1;
                    end
                    if (bytes_counted != '1)
                        bytes_counted = bytes_counted + 1'b1;
                end
            end
            OP_RESTART:
                readout_pos = '0;
            OP_CLEAR:
            begin
                seen_mask     = '0;
                distinct_seen = '0;
                bytes_counted = '0;
                readout_pos   = '0;
            end
            default:
            begin
                r = '0;
                if (readout_pos < distinct_seen)
                begin
                    r.entry_valid = 1'b1;
                    r.symbol      = arrival_order[readout_pos[BYTE_W-1:0]];
                    // clamp wide weights to the output field
                    if (64'(sym_weight[r.symbol]) > 64'hFFFF_FFFF)
                        r.weight = '1;
                    else
                        r.weight = OUT_WT_W'(sym_weight[r.symbol]);
                    readout_pos = readout_pos + 1'b1;
                end
                r.distinct_count = distinct_seen;
                r.total_count    = bytes_counted;
                expected_reads.push_back(r);
            end
        endcase
    endtask

    task automatic check_readout(input bhfs_out_t got);
        bhfs_out_t want;
        if (expected_reads.size() == 0)
        begin
            report_mismatch("result strobe with no read pending");
            return;
        end
        want = expected_reads.pop_front();
        if (got.entry_valid !== want.entry_valid)
            report_mismatch($sformatf("entry_valid %0b, want %0b",
                got.entry_valid, want.entry_valid));
        if (got.symbol !== want.symbol)
            report_mismatch($sformatf("symbol %0h, want %0h", got.symbol, want.symbol));
        if (got.weight !== want.weight)
            report_mismatch($sformatf("weight %0d, want %0d", got.weight, want.weight));
        if (got.distinct_count !== want.distinct_count)
            report_mismatch($sformatf("distinct_count %0d, want %0d",
                got.distinct_count, want.distinct_count));
        if (got.total_count !== want.total_count)
            report_mismatch($sformatf("total_count %0d, want %0d",
                got.total_count, want.total_count));
    endtask

    // Monitor: results first, since a strobe always belongs to an earlier word.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else if (rst_n)
        begin
            if (result_valid === 1'b1)
                check_readout(result);
            word_taken <= start && !busy;
            if (start && !busy)
            begin
                histogram_step(command);
                words_taken++;
            end
        end
    end

    // Driver: advance on a taken word, hold otherwise; no idling in a middle stretch.
    always @(negedge clk)
    begin
        if (rst_n && (!start || word_taken))
        begin
            if (pending_words.size() != 0 &&
                ((words_sent >= 400 && words_sent < 700) || $urandom_range(99) >= 10))
            begin
                command <= pending_words.pop_front();
                start   <= 1'b1;
                words_sent++;
            end
            else
                start <= 1'b0;
        end
    end

    initial
    begin
        int perm [SYMBOLS];
        int n;
        int j;
        int tmp;
        int kind;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] base;
        bit filled;

        filled = 1'b0;

        // empty table, extremes, repeats, exhausted readout
        push_word(OP_READ, 8'h00);
        push_word(OP_COUNT, 8'h00);
        push_word(OP_COUNT, 8'hFF);
        push_word(OP_COUNT, 8'h00);
        push_word(OP_COUNT, 8'hA5);
        push_word(OP_COUNT, 8'h5A);
        push_word(OP_COUNT, 8'hFF);
        repeat (6) push_word(OP_READ, 8'hFF);
        push_word(OP_RESTART, 8'h00);
        push_word(OP_READ, 8'h00);
        push_word(OP_COUNT, 8'h01);
        repeat (4) push_word(OP_READ, 8'h00);
        push_word(OP_CLEAR, 8'hFF);
        push_word(OP_READ, 8'h00);
        push_word(OP_COUNT, 8'h80);
        push_word(OP_RESTART, 8'h00);
        push_word(OP_READ, 8'h00);

        while (words_queued < 1225)
        begin
            if (!filled && words_queued > 400)
            begin
                // every byte value once, in shuffled order, then read past the end
                filled = 1'b1;
                for (int i = 0; i < SYMBOLS; i++)
                    perm[i] = i;
                for (int i = SYMBOLS - 1; i > 0; i--)
                begin
                    j       = $urandom_range(i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                push_word(OP_CLEAR, 8'h00);
                for (int i = 0; i < SYMBOLS; i++)
                    push_word(OP_COUNT, BYTE_W'(perm[i]));
                push_word(OP_COUNT, BYTE_W'(perm[0]));
                push_word(OP_RESTART, 8'h00);
                repeat (SYMBOLS + 2) push_word(OP_READ, BYTE_W'($urandom_range(255)));
            end
            kind = $urandom_range(9);
            if (kind < 7)
            begin
                if ($urandom_range(1) == 1)
                    push_word(OP_CLEAR, BYTE_W'($urandom_range(255)));
                case ($urandom_range(2))
                    0:       mask = 8'h03;
                    1:       mask = 8'h0F;
                    default: mask = 8'hFF;
                endcase
                base = BYTE_W'($urandom_range(255)) & ~mask;
                n    = $urandom_range(30, 1);
                repeat (n)
                    push_word(OP_COUNT, (BYTE_W'($urandom_range(255)) & mask) | base);
                push_word(OP_RESTART, BYTE_W'($urandom_range(255)));
                repeat ($urandom_range(n + 2, 1))
                begin
                    // drop a count into the readout now and then
                    if ($urandom_range(7) == 0)
                        push_word(OP_COUNT, (BYTE_W'($urandom_range(255)) & mask) | base);
                    push_word(OP_READ, BYTE_W'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(10, 1))
                    push_word(bhfs_op_t'($urandom_range(3)), BYTE_W'($urandom_range(255)));
            end
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (words_taken != words_queued || expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_reads.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
hdl/bhfs_pkg.sv
hdl/bhfs_order_mem.sv
hdl/bhfs_weight_mem.sv
hdl/byte_histogram_first_seen_top.sv
tb/byte_histogram_first_seen_top_test.sv
